// ===== rtl/three_region_page_cache_directory_top_macros.svh =====
// assertion macros for the page cache directory checker
`ifndef THREE_REGION_PAGE_CACHE_DIRECTORY_TOP_MACROS_SVH
`define THREE_REGION_PAGE_CACHE_DIRECTORY_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define TRPCD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trpcd check failed");

// next-cycle implication, disabled while reset is low
`define TRPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trpcd check failed");

`endif

// ===== rtl/trpcd_pkg.sv =====
// shared types and constants of the page cache directory
`default_nettype none

package trpcd_pkg;

    localparam int CMD_W      = 3;
    localparam int PAGE_W     = 32;
    localparam int LEVEL_W    = 8;
    localparam int SLOT_OUT_W = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_GET       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MARK      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FREE      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH_BOT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FLUSH_ALL = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNT = 1'd1;

    localparam logic [LEVEL_W-1:0] TOP_LIMIT_RESET = 8'd1;
    localparam logic [PAGE_W-1:0]  COUNT_RESET     = 32'd0;

    // one directory entry as held in the tag memory
    typedef struct packed {
        logic              valid;
        logic              dirty;
        logic [PAGE_W-1:0] page;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// ===== rtl/three_region_page_cache_directory_top.sv =====
// page cache directory top: walk for get, lookup, flush; one-slot update for mark, free
// get and lookup: result from the final state after the walk, next request once busy drops
// flush: same walk, write-back results one per valid dirty entry; bottom flush skips the
// walk if its first slot is empty; mark dirty and free slot: skipped when out of range;
// throughput set by the single tag memory walked one entry per cycle; after reset a sweep
// clearing all TOTAL entries keeps busy high, configuration writes are taken during it
`default_nettype none

module three_region_page_cache_directory_top #(
    parameter int TOP_REGION_SLOTS = 16,
    parameter int MID_REGION_SLOTS = 16,
    parameter int LOW_REGION_SLOTS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // request handshake
    input  wire logic                                start,
    output logic                                     busy,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [trpcd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [trpcd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // request fields
    input  wire logic [trpcd_pkg::CMD_W-1:0]         i_cmd,
    input  wire logic [trpcd_pkg::PAGE_W-1:0]        i_page_num,
    input  wire logic [trpcd_pkg::LEVEL_W-1:0]       i_level,
    input  wire logic                                i_fresh_page,
    input  wire logic [trpcd_pkg::SLOT_OUT_W-1:0]    i_target_slot,
    // result strobe and fields
    output logic                                     o_result_valid,
    output logic                                     o_hit,
    output logic      [trpcd_pkg::SLOT_OUT_W-1:0]    o_slot,
    output logic                                     o_fetch_needed,
    output logic                                     o_full_error,
    output logic                                     o_writeback,
    output logic      [trpcd_pkg::PAGE_W-1:0]        o_writeback_page,
    output logic      [trpcd_pkg::PAGE_W-1:0]        o_page_count,
    output logic                                     o_last
);

    // directory geometry
    localparam int TOTAL     = TOP_REGION_SLOTS + MID_REGION_SLOTS + LOW_REGION_SLOTS;
    localparam int MID_START = TOP_REGION_SLOTS;
    localparam int LOW_START = TOP_REGION_SLOTS + MID_REGION_SLOTS;
    localparam int SLOT_W    = $clog2(TOTAL);
    localparam int ENTRY_W   = trpcd_pkg::ENTRY_W;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TOTAL - 1);
    localparam logic [SLOT_W-1:0] MID_IDX  = SLOT_W'(MID_START);
    localparam logic [SLOT_W-1:0] LOW_IDX  = SLOT_W'(LOW_START);

    // region codes
    localparam logic [1:0] REG_TOP = 2'd0;
    localparam logic [1:0] REG_MID = 2'd1;
    localparam logic [1:0] REG_LOW = 2'd2;

    // sequencer states
    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_PRE       = 3'd2;
    localparam logic [2:0] S_CHECK     = 3'd3;
    localparam logic [2:0] S_WALK      = 3'd4;
    localparam logic [2:0] S_SINGLE_RD = 3'd5;
    localparam logic [2:0] S_SINGLE_WR = 3'd6;
    localparam logic [2:0] S_FIN       = 3'd7;

    // control state
    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_addr, n_addr;       // next entry to read
    logic              r_issue, n_issue;     // a walk read is issued this cycle
    logic              r_pvld, n_pvld;       // read data of r_pidx is valid
    logic [SLOT_W-1:0] r_pidx, n_pidx;       // entry whose data is on the ram output
    logic [trpcd_pkg::LEVEL_W-1:0] r_limit, n_limit;
    logic [trpcd_pkg::PAGE_W-1:0]  r_count, n_count;

    // search bookkeeping, one slot per region
    logic [2:0]        r_act, n_act;             // region still before its first empty slot
    logic [2:0]        r_free_ok, n_free_ok;     // region has a first empty slot
    logic [SLOT_W-1:0] r_free_idx [3];
    logic [SLOT_W-1:0] n_free_idx [3];
    logic [2:0]        r_free_dirty, n_free_dirty;
    logic              r_hit, n_hit;
    logic [SLOT_W-1:0] r_hit_idx, n_hit_idx;
    logic              r_run_act, n_run_act;     // bottom run still being freed

    // latched request
    logic [trpcd_pkg::CMD_W-1:0]      r_cmd;
    logic [trpcd_pkg::PAGE_W-1:0]     r_page;
    logic [trpcd_pkg::LEVEL_W-1:0]    r_level;
    logic                             r_fresh;
    logic [trpcd_pkg::SLOT_OUT_W-1:0] r_target;
    logic [SLOT_W-1:0]                r_tidx;

    // result registers
    logic                             r_out_valid, n_out_valid;
    logic                             r_out_hit, n_out_hit;
    logic [trpcd_pkg::SLOT_OUT_W-1:0] r_out_slot, n_out_slot;
    logic                             r_out_fetch, n_out_fetch;
    logic                             r_out_full, n_out_full;
    logic                             r_out_wb, n_out_wb;
    logic [trpcd_pkg::PAGE_W-1:0]     r_out_wb_page, n_out_wb_page;
    logic                             r_out_last, n_out_last;

    // tag memory port
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_wr_addr;
    logic [ENTRY_W-1:0]   ram_wr_data;
    logic [SLOT_W-1:0]    ram_rd_addr;
    logic [ENTRY_W-1:0]   ram_rd_data;

    trpcd_pkg::t_entry rd_entry;
    trpcd_pkg::t_entry wr_entry;
    logic [1:0]        p_reg;
    logic              accept;

    // fill choice for a get miss
    logic              fill_ok;
    logic [SLOT_W-1:0] fill_idx;
    logic              fill_dirty;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign rd_entry = trpcd_pkg::t_entry'(ram_rd_data);
    assign p_reg    = (r_pidx < MID_IDX) ? REG_TOP : ((r_pidx < LOW_IDX) ? REG_MID : REG_LOW);

    trpcd_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TOTAL)
    ) u_tag_ram (
        .i_clk    (i_clk),
        .i_we     (ram_we),
        .i_wr_addr(ram_wr_addr),
        .i_wr_data(ram_wr_data),
        .i_rd_addr(ram_rd_addr),
        .o_rd_data(ram_rd_data)
    );

    // read address: fixed probe for the bottom check, target slot for single-slot updates
    always_comb begin
        case (r_state)
            S_PRE:       ram_rd_addr = LOW_IDX;
            S_SINGLE_RD: ram_rd_addr = r_tidx;
            default:     ram_rd_addr = r_addr;
        endcase
    end

    // first free slot: top only within the level limit, then middle, then bottom
    always_comb begin
        fill_ok    = 1'b1;
        fill_idx   = r_free_idx[REG_TOP];
        fill_dirty = r_free_dirty[REG_TOP];
        if (r_free_ok[REG_TOP] && (r_level <= r_limit)) begin
            fill_idx   = r_free_idx[REG_TOP];
            fill_dirty = r_free_dirty[REG_TOP];
        end else if (r_free_ok[REG_MID]) begin
            fill_idx   = r_free_idx[REG_MID];
            fill_dirty = r_free_dirty[REG_MID];
        end else if (r_free_ok[REG_LOW]) begin
            fill_idx   = r_free_idx[REG_LOW];
            fill_dirty = r_free_dirty[REG_LOW];
        end else begin
            fill_ok = 1'b0;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue      = r_issue;
        n_pvld       = 1'b0;
        n_pidx       = r_pidx;
        n_limit      = r_limit;
        n_count      = r_count;
        n_act        = r_act;
        n_free_ok    = r_free_ok;
        n_free_idx   = r_free_idx;
        n_free_dirty = r_free_dirty;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_run_act    = r_run_act;

        n_out_valid   = 1'b0;
        n_out_hit     = 1'b0;
        n_out_slot    = '0;
        n_out_fetch   = 1'b0;
        n_out_full    = 1'b0;
        n_out_wb      = 1'b0;
        n_out_wb_page = '0;
        n_out_last    = 1'b0;

        ram_we      = 1'b0;
        ram_wr_addr = r_pidx;
        wr_entry    = rd_entry;
        ram_wr_data = wr_entry;

        case (r_state)
            // sweep zeros through the tag memory after reset
            S_CLEAR: begin
                ram_we      = 1'b1;
                ram_wr_addr = r_addr;
                ram_wr_data = '0;
                n_addr      = r_addr + 1'b1;
                if (r_addr == LAST_IDX) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_addr    = '0;
                    n_act     = 3'b111;
                    n_free_ok = 3'b000;
                    n_hit     = 1'b0;
                    n_run_act = 1'b1;
                    case (i_cmd)
                        trpcd_pkg::CMD_GET, trpcd_pkg::CMD_LOOKUP,
                        trpcd_pkg::CMD_FLUSH_ALL: begin
                            n_issue = 1'b1;
                            n_state = S_WALK;
                        end
                        trpcd_pkg::CMD_MARK, trpcd_pkg::CMD_FREE: begin
                            // out-of-range slots are ignored
                            if (int'(i_target_slot) < TOTAL) begin
                                n_state = S_SINGLE_RD;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        trpcd_pkg::CMD_FLUSH_BOT: begin
                            n_state = S_PRE;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            // probe the first bottom slot
            S_PRE: begin
                n_state = S_CHECK;
            end

            S_CHECK: begin
                if (rd_entry.valid) begin
                    n_issue = 1'b1;
                    n_state = S_WALK;
                end else begin
                    n_state = S_FIN;
                end
            end

            // one read issued and one entry processed per cycle
            S_WALK: begin
                if (r_issue) begin
                    n_addr = r_addr + 1'b1;
                    n_pidx = r_addr;
                    n_pvld = 1'b1;
                    if (r_addr == LAST_IDX) begin
                        n_issue = 1'b0;
                    end
                end
                if (r_pvld) begin
                    case (r_cmd)
                        trpcd_pkg::CMD_GET, trpcd_pkg::CMD_LOOKUP: begin
                            if (!r_hit && r_act[p_reg]) begin
                                if (rd_entry.valid) begin
                                    if (rd_entry.page == r_page) begin
                                        n_hit     = 1'b1;
                                        n_hit_idx = r_pidx;
                                    end
                                end else begin
                                    n_act[p_reg]        = 1'b0;
                                    n_free_ok[p_reg]    = 1'b1;
                                    n_free_idx[p_reg]   = r_pidx;
                                    n_free_dirty[p_reg] = rd_entry.dirty;
                                end
                            end
                        end
                        trpcd_pkg::CMD_FLUSH_BOT, trpcd_pkg::CMD_FLUSH_ALL: begin
                            // clean valid dirty entries, free per command
                            wr_entry.dirty = rd_entry.dirty & ~rd_entry.valid;
                            if (r_cmd == trpcd_pkg::CMD_FLUSH_ALL) begin
                                wr_entry.valid = 1'b0;
                            end else if ((p_reg == REG_LOW) && r_run_act) begin
                                if (rd_entry.valid) begin
                                    wr_entry.valid = 1'b0;
                                end else begin
                                    n_run_act = 1'b0;
                                end
                            end
                            ram_we      = 1'b1;
                            ram_wr_addr = r_pidx;
                            ram_wr_data = wr_entry;
                            if (rd_entry.valid && rd_entry.dirty) begin
                                n_out_valid   = 1'b1;
                                n_out_slot    = trpcd_pkg::SLOT_OUT_W'(r_pidx);
                                n_out_wb      = 1'b1;
                                n_out_wb_page = rd_entry.page;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (!r_issue) begin
                        n_state = S_FIN;
                    end
                end
            end

            S_SINGLE_RD: begin
                n_state = S_SINGLE_WR;
            end

            // read-modify-write of the target slot
            S_SINGLE_WR: begin
                if (r_cmd == trpcd_pkg::CMD_MARK) begin
                    wr_entry.dirty = 1'b1;
                end else begin
                    wr_entry.valid = 1'b0;
                end
                ram_we      = 1'b1;
                ram_wr_addr = r_tidx;
                ram_wr_data = wr_entry;
                n_state     = S_FIN;
            end

            // final result of every request
            S_FIN: begin
                n_out_valid = 1'b1;
                n_out_last  = 1'b1;
                n_state     = S_IDLE;
                case (r_cmd)
                    trpcd_pkg::CMD_GET: begin
                        if (r_hit) begin
                            n_out_hit  = 1'b1;
                            n_out_slot = trpcd_pkg::SLOT_OUT_W'(r_hit_idx);
                        end else if (fill_ok) begin
                            wr_entry.valid = 1'b1;
                            wr_entry.dirty = fill_dirty;
                            wr_entry.page  = r_page;
                            ram_we         = 1'b1;
                            ram_wr_addr    = fill_idx;
                            ram_wr_data    = wr_entry;
                            n_out_slot     = trpcd_pkg::SLOT_OUT_W'(fill_idx);
                            n_out_fetch    = ~r_fresh;
                            if (r_fresh) begin
                                n_count = r_count + 1'b1;
                            end
                        end else begin
                            n_out_full = 1'b1;
                        end
                    end
                    trpcd_pkg::CMD_LOOKUP: begin
                        if (r_hit) begin
                            n_out_hit  = 1'b1;
                            n_out_slot = trpcd_pkg::SLOT_OUT_W'(r_hit_idx);
                        end else begin
                            n_out_fetch = 1'b1;
                        end
                    end
                    trpcd_pkg::CMD_MARK, trpcd_pkg::CMD_FREE: begin
                        n_out_slot = r_target;
                    end
                    default: begin
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // user sends configuration writes only while no request is in flight; unchecked
        if (i_cfg_we) begin
            case (i_cfg_idx)
                trpcd_pkg::CFG_TOP_LIMIT:  n_limit = i_cfg_data[trpcd_pkg::LEVEL_W-1:0];
                trpcd_pkg::CFG_INIT_COUNT: n_count = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_pvld      <= 1'b0;
            r_limit     <= trpcd_pkg::TOP_LIMIT_RESET;
            r_count     <= trpcd_pkg::COUNT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issue     <= n_issue;
            r_pvld      <= n_pvld;
            r_limit     <= n_limit;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and bookkeeping registers
    always_ff @(posedge i_clk) begin
        r_pidx        <= n_pidx;
        r_act         <= n_act;
        r_free_ok     <= n_free_ok;
        r_free_idx    <= n_free_idx;
        r_free_dirty  <= n_free_dirty;
        r_hit         <= n_hit;
        r_hit_idx     <= n_hit_idx;
        r_run_act     <= n_run_act;
        r_out_hit     <= n_out_hit;
        r_out_slot    <= n_out_slot;
        r_out_fetch   <= n_out_fetch;
        r_out_full    <= n_out_full;
        r_out_wb      <= n_out_wb;
        r_out_wb_page <= n_out_wb_page;
        r_out_last    <= n_out_last;
        if (accept) begin
            r_cmd    <= i_cmd;
            r_page   <= i_page_num;
            r_level  <= i_level;
            r_fresh  <= i_fresh_page;
            r_target <= i_target_slot;
            r_tidx   <= SLOT_W'(i_target_slot);
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_hit            = r_out_hit;
    assign o_slot           = r_out_slot;
    assign o_fetch_needed   = r_out_fetch;
    assign o_full_error     = r_out_full;
    assign o_writeback      = r_out_wb;
    assign o_writeback_page = r_out_wb_page;
    assign o_page_count     = r_count;
    assign o_last           = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/trpcd_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module trpcd_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 40
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/trpcd_checker.sv =====
// port-level checker for the page cache directory, bound to the top level
`default_nettype none

`include "three_region_page_cache_directory_top_macros.svh"

module trpcd_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire logic                             o_result_valid,
    input wire logic                             o_hit,
    input wire logic [trpcd_pkg::SLOT_OUT_W-1:0] o_slot,
    input wire logic                             o_full_error,
    input wire logic                             o_writeback,
    input wire logic                             o_last
);

    // an accepted request always occupies the block
    `TRPCD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // the final result comes once the block is free again
    `TRPCD_ASSERT_SAME(a_last_idle, i_clk, i_rst_n, o_result_valid && o_last, !busy)

    // every earlier result is a write-back during a flush
    `TRPCD_ASSERT_SAME(a_mid_wb, i_clk, i_rst_n, o_result_valid && !o_last, o_writeback && busy)

    // a full directory gives a final miss at slot zero
    `TRPCD_ASSERT_SAME(a_full_final, i_clk, i_rst_n, o_full_error,
        o_result_valid && o_last && !o_hit && (o_slot == '0))

endmodule

bind three_region_page_cache_directory_top trpcd_checker u_trpcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_result_valid(o_result_valid),
    .o_hit         (o_hit),
    .o_slot        (o_slot),
    .o_full_error  (o_full_error),
    .o_writeback   (o_writeback),
    .o_last        (o_last)
);

`default_nettype wire
